// File: hdl/dsc_pkg.sv
package dsc_pkg;

  localparam int unsigned MAX_MODULUS = 1024;
  localparam int unsigned MAX_ITEMS   = 65536;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned RES_W   = $clog2(MAX_MODULUS);
  localparam int unsigned K_W     = $clog2(MAX_MODULUS + 1);
  localparam int unsigned HIST_W  = $clog2(MAX_ITEMS + 2);
  localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 2);
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned MEM_W   = EPOCH_W + HIST_W;
  localparam int unsigned STEP_W  = $clog2(DATA_W);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] mag;
    logic [K_W-1:0]    k;
  } rem_req_t;

  typedef struct packed {
    logic           done;
    logic [K_W-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [HIST_W-1:0]  count;
  } hist_word_t;

endpackage

// File: hdl/dsc_if.sv
interface dsc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dsc_pkg::DATA_W-1:0]   value;
  logic                                last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface dsc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dsc_pkg::DATA_W-1:0]   subarray_count;
  logic                         last_out;
  logic                         overflow;

  modport source (output valid, subarray_count, last_out, overflow, input ready);
  modport sink (input valid, subarray_count, last_out, overflow, output ready);
endinterface

interface dsc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dsc_pkg::CFG_W-1:0]  modulus;

  modport source (output valid, modulus, input ready);
  modport sink (input valid, modulus, output ready);
endinterface

// File: hdl/divisible_subarray_counter.sv
// channel  dir  handshake     payload
// in_i     in   valid/ready   value (s32), last
// out_o    out  valid/ready   subarray_count (u32), last_out, overflow
// cfg_i    in   valid/ready   modulus (u11)
//
// an item is accepted, then passes the bit-serial remainder unit (32 steps and its
// done flag), one histogram read and one write-back; past the item limit it skips
// the remainder unit and the histogram.
// after reset a clearing pass sweeps the 1024-entry histogram with in_i held off;
// the same pass runs once every 255 sequence ends or modulus writes, when the
// histogram epoch wraps.
// the result sits in an output register, a new item is taken while it waits;
// the write-back stalls only while a previous result is still not taken.
module divisible_subarray_counter (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsc_in_if.sink           in_i,
  dsc_out_if.source        out_o,
  dsc_cfg_if.sink          cfg_i
);

  localparam int unsigned AW = $clog2(dsc_pkg::MAX_MODULUS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_RD    = 5'b01000,
    S_UPD   = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [dsc_pkg::K_W-1:0]       k_q, k_d;
  logic [dsc_pkg::RES_W-1:0]     prefix_q, prefix_d;
  logic [dsc_pkg::RES_W-1:0]     res_q, res_d;
  logic [dsc_pkg::DATA_W-1:0]    total_q, total_d;
  logic [dsc_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [dsc_pkg::EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [AW-1:0]                 clr_q, clr_d;
  logic                          neg_q, neg_d;
  logic                          last_q, last_d;
  logic                          over_q, over_d;
  logic                          out_valid_q, out_valid_d;
  logic [dsc_pkg::DATA_W-1:0]    out_count_q, out_count_d;
  logic                          out_last_q, out_last_d;
  logic                          out_ovf_q, out_ovf_d;

  dsc_pkg::rem_req_t             rem_req;
  dsc_pkg::rem_rsp_t             rem_rsp;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [dsc_pkg::MEM_W-1:0]     ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [dsc_pkg::MEM_W-1:0]     ram_rdata;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          in_over;
  logic [31:0]                   mod_ext;
  logic [dsc_pkg::K_W-1:0]       k_eff;
  logic [dsc_pkg::K_W-1:0]       r_norm;
  logic [dsc_pkg::K_W:0]         res_sum;
  logic [dsc_pkg::K_W:0]         res_full;
  logic [dsc_pkg::RES_W-1:0]     res_calc;
  dsc_pkg::hist_word_t           rd_word;
  dsc_pkg::hist_word_t           wr_word;
  logic [dsc_pkg::HIST_W-1:0]    hit;
  logic [dsc_pkg::DATA_W:0]      total_sum;
  logic [dsc_pkg::DATA_W-1:0]    total_new;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_over     = (cnt_q >= dsc_pkg::CNT_W'(dsc_pkg::MAX_ITEMS));

  // modulus zero acts as one, above the histogram depth it is clamped
  always_comb begin
    mod_ext = 32'(cfg_i.modulus);
    if (mod_ext == 32'd0) begin
      k_eff = dsc_pkg::K_W'(1);
    end else if (mod_ext > 32'(dsc_pkg::MAX_MODULUS)) begin
      k_eff = dsc_pkg::K_W'(dsc_pkg::MAX_MODULUS);
    end else begin
      k_eff = dsc_pkg::K_W'(mod_ext);
    end
  end

  // fold sign into the magnitude remainder, then add to the prefix residue
  always_comb begin
    if (neg_q && (rem_rsp.rem != '0)) begin
      r_norm = k_q - rem_rsp.rem;
    end else begin
      r_norm = rem_rsp.rem;
    end
    res_sum = (dsc_pkg::K_W + 1)'(prefix_q) + (dsc_pkg::K_W + 1)'(r_norm);
    if (res_sum >= {1'b0, k_q}) begin
      res_full = res_sum - {1'b0, k_q};
    end else begin
      res_full = res_sum;
    end
    res_calc = dsc_pkg::RES_W'(res_full);
  end

  // an entry with a stale epoch reads as its sequence-start value: one for residue zero, else zero
  always_comb begin
    rd_word = dsc_pkg::hist_word_t'(ram_rdata);
    if (rd_word.tag == epoch_q) begin
      hit = rd_word.count;
    end else if (res_q == '0) begin
      hit = dsc_pkg::HIST_W'(1);
    end else begin
      hit = '0;
    end
    wr_word.tag = epoch_q;
    if (hit < dsc_pkg::HIST_W'(dsc_pkg::MAX_ITEMS + 1)) begin
      wr_word.count = hit + dsc_pkg::HIST_W'(1);
    end else begin
      wr_word.count = hit;
    end
    total_sum = {1'b0, total_q} + (dsc_pkg::DATA_W + 1)'(hit);
    total_new = total_sum[dsc_pkg::DATA_W] ? '1 : total_sum[dsc_pkg::DATA_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    prefix_d    = prefix_q;
    res_d       = res_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    neg_d       = neg_q;
    last_d      = last_q;
    over_d      = over_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = res_q;
    ram_wdata   = wr_word;
    ram_re      = 1'b0;
    ram_raddr   = res_calc;
    rem_req     = '0;
    rem_req.k   = k_q;
    rem_req.mag = in_i.value[dsc_pkg::DATA_W-1] ? (~in_i.value + 1'b1) : in_i.value;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(dsc_pkg::MAX_MODULUS - 1)) begin
          clr_d   = '0;
          epoch_d = dsc_pkg::EPOCH_W'(1);
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          neg_d         = in_i.value[dsc_pkg::DATA_W-1];
          last_d        = in_i.last;
          over_d        = in_over;
          rem_req.start = !in_over;
          state_d       = in_over ? S_UPD : S_DIV;
        end
      end
      S_DIV: begin
        if (rem_rsp.done) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        res_d   = res_calc;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_last_d  = last_q;
          out_ovf_d   = over_q;
          if (over_q) begin
            cnt_d       = dsc_pkg::CNT_W'(dsc_pkg::MAX_ITEMS + 1);
            out_count_d = total_q;
          end else begin
            ram_we      = 1'b1;
            total_d     = total_new;
            cnt_d       = cnt_q + dsc_pkg::CNT_W'(1);
            prefix_d    = res_q;
            out_count_d = total_new;
          end
          state_d = S_IDLE;
          if (last_q) begin
            prefix_d = '0;
            total_d  = '0;
            cnt_d    = '0;
            if (epoch_q == '1) begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end else begin
              epoch_d = epoch_q + dsc_pkg::EPOCH_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // a modulus write restarts the sequence
    if (cfg_fire) begin
      k_d      = k_eff;
      prefix_d = '0;
      total_d  = '0;
      cnt_d    = '0;
      if (state_q != S_CLEAR) begin
        if (epoch_q == '1) begin
          clr_d   = '0;
          state_d = S_CLEAR;
        end else begin
          epoch_d = epoch_q + dsc_pkg::EPOCH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      k_q         <= dsc_pkg::K_W'(1);
      prefix_q    <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      epoch_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      prefix_q    <= prefix_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    neg_q       <= neg_d;
    last_q      <= last_d;
    over_q      <= over_d;
    out_count_q <= out_count_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  dsc_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  dsc_ram #(
    .WIDTH (dsc_pkg::MEM_W),
    .DEPTH (dsc_pkg::MAX_MODULUS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.subarray_count = out_count_q;
  assign out_o.last_out       = out_last_q;
  assign out_o.overflow       = out_ovf_q;

`ifndef SYNTH
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_UPD || state_q == S_CLEAR))
    else $error("histogram written outside update or clearing pass");

  a_rem_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_rsp.done |-> (state_q == S_DIV))
    else $error("remainder result arrived with no item waiting");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (epoch_q != '0))
    else $error("epoch zero in use, cleared entries would read as live");

  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((dsc_pkg::K_W + 1)'(prefix_q) < {1'b0, k_q}))
    else $error("prefix residue not below the modulus");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dsc_pkg::CNT_W'(dsc_pkg::MAX_ITEMS + 1))
    else $error("item counter past its saturation value");
`endif

endmodule

// File: hdl/dsc_ram.sv
module dsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dsc_rem.sv
module dsc_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsc_pkg::rem_req_t req_i,
  output dsc_pkg::rem_rsp_t rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [dsc_pkg::STEP_W-1:0]   step_q;
  logic [dsc_pkg::DATA_W-1:0]   dvd_q;
  logic [dsc_pkg::K_W-1:0]      rem_q;
  logic [dsc_pkg::K_W-1:0]      k_q;
  logic [dsc_pkg::K_W:0]        trial;
  logic [dsc_pkg::K_W-1:0]      rem_d;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial = {rem_q, dvd_q[dsc_pkg::DATA_W-1]};
    if (trial >= {1'b0, k_q}) begin
      rem_d = dsc_pkg::K_W'(trial - {1'b0, k_q});
    end else begin
      rem_d = dsc_pkg::K_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      k_q    <= dsc_pkg::K_W'(1);
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        dvd_q  <= req_i.mag;
        rem_q  <= '0;
        k_q    <= req_i.k;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        dvd_q  <= {dvd_q[dsc_pkg::DATA_W-2:0], 1'b0};
        step_q <= step_q + dsc_pkg::STEP_W'(1);
        if (step_q == dsc_pkg::STEP_W'(dsc_pkg::DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
